[design/tcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcd_pkg
// Parse phase codes, keyword tables and character helpers for the text
// command decoder.
// ----------------------------------------------------------------------------
package tcd_pkg;

  typedef logic [4:0] phase_t;
  typedef logic [3:0] kw_pos_t;
  typedef logic [7:0] char_t;

  // Parse phases
  localparam phase_t PH_START   = 5'd0;
  localparam phase_t PH_KW_EE   = 5'd1;
  localparam phase_t PH_EE_SP   = 5'd2;
  localparam phase_t PH_R_SP    = 5'd3;
  localparam phase_t PH_R_X     = 5'd4;
  localparam phase_t PH_R_DIG   = 5'd5;
  localparam phase_t PH_W_SP    = 5'd6;
  localparam phase_t PH_W_X     = 5'd7;
  localparam phase_t PH_W_DIG   = 5'd8;
  localparam phase_t PH_W_SP2   = 5'd9;
  localparam phase_t PH_V_X     = 5'd10;
  localparam phase_t PH_V_DIG   = 5'd11;
  localparam phase_t PH_DONE_R  = 5'd12;
  localparam phase_t PH_DONE_W  = 5'd13;
  localparam phase_t PH_KW_CAP  = 5'd14;
  localparam phase_t PH_CAP_END = 5'd15;
  localparam phase_t PH_FAIL    = 5'd16;

  // Keyword lengths
  localparam kw_pos_t KW_EE_LEN  = 4'd6;
  localparam kw_pos_t KW_CAP_LEN = 4'd9;

  // Characters of interest
  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_E     = 8'h45;
  localparam char_t CH_C     = 8'h43;
  localparam char_t CH_R     = 8'h52;
  localparam char_t CH_W     = 8'h57;
  localparam char_t CH_X_UP  = 8'h58;
  localparam char_t CH_X_LO  = 8'h78;

  // "EEPROM" by position
  function automatic char_t kw_ee_char(input kw_pos_t pos);
    char_t c;
    case (pos)
      4'd0:    c = 8'h45; // E
      4'd1:    c = 8'h45; // E
      4'd2:    c = 8'h50; // P
      4'd3:    c = 8'h52; // R
      4'd4:    c = 8'h4F; // O
      4'd5:    c = 8'h4D; // M
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Touch sensor keyword by position
  function automatic char_t kw_cap_char(input kw_pos_t pos);
    char_t c;
    case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h41; // A
      4'd2:    c = 8'h50; // P
      4'd3:    c = 8'h5F; // _
      4'd4:    c = 8'h54; // T
      4'd5:    c = 8'h4F; // O
      4'd6:    c = 8'h55; // U
      4'd7:    c = 8'h43; // C
      4'd8:    c = 8'h48; // H
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Hex digit decode: {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input char_t c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else                               r = 5'd0;
    return r;
  endfunction

endpackage

[design/text_command_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_decoder
// Character-at-a-time parser for EEPROM read/write and touch sensor commands.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one ASCII character per transfer (in_char_in);
//   a zero byte ends the command. Every character is consumed in the cycle
//   it is transferred, so one character per cycle is sustained unless a
//   zero byte is held back by a stalled result.
//   Each zero byte produces exactly one result on the output channel in the
//   cycle after its transfer, from the output register: cmd_valid, device,
//   read/write, the low 16 address bits and the low 8 data bits. Non-zero
//   characters produce no result.
//   When the receiver stalls, the result holds in the output register.
//   Ordinary characters are still taken meanwhile; only a zero byte is
//   stalled until the waiting result has been transferred.
//   Reset (rst_n low, synchronous) returns the parser to the start of a
//   command and empties the output register.
// ----------------------------------------------------------------------------
module text_command_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcd_pkg::char_t     in_char_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_cmd_valid,
  output logic               out_target_device,
  output logic               out_access_kind,
  output logic [15:0]        out_target_address,
  output logic [7:0]         out_write_data
);
  import tcd_pkg::*;

  phase_t      phase_r, phase_nxt;
  kw_pos_t     kw_pos_r, kw_pos_nxt;
  logic [15:0] addr_acc_r, addr_acc_nxt;
  logic [7:0]  val_acc_r, val_acc_nxt;
  logic        digit_seen_r, digit_seen_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        res_valid_r, res_valid_nxt;
  logic        res_dev_r, res_dev_nxt;
  logic        res_kind_r, res_kind_nxt;
  logic [15:0] res_addr_r, res_addr_nxt;
  logic [7:0]  res_data_r, res_data_nxt;

  logic        in_xfer;
  logic        is_term;
  logic        load_res;
  logic [4:0]  hex;
  logic        is_hex;

  // Handshake: only a terminator needs the output register
  assign is_term  = (in_char_in == CH_NUL);
  assign in_stall = out_valid_r && out_stall && is_term;
  assign in_xfer  = in_valid && !in_stall;
  assign load_res = in_xfer && is_term;
  assign hex      = hex_decode(in_char_in);
  assign is_hex   = hex[4];

  // Parser next state
  always_comb begin
    phase_nxt      = phase_r;
    kw_pos_nxt     = kw_pos_r;
    addr_acc_nxt   = addr_acc_r;
    val_acc_nxt    = val_acc_r;
    digit_seen_nxt = digit_seen_r;
    if (in_xfer && is_term) begin
      phase_nxt      = PH_START;
      kw_pos_nxt     = '0;
      addr_acc_nxt   = '0;
      val_acc_nxt    = '0;
      digit_seen_nxt = 1'b0;
    end else if (in_xfer) begin
      unique case (phase_r)
        PH_START: begin
          if (in_char_in == CH_E) begin
            phase_nxt  = PH_KW_EE;
            kw_pos_nxt = 4'd1;
          end else if (in_char_in == CH_C) begin
            phase_nxt  = PH_KW_CAP;
            kw_pos_nxt = 4'd1;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_KW_EE: begin
          if (kw_pos_r < KW_EE_LEN && in_char_in == kw_ee_char(kw_pos_r)) begin
            kw_pos_nxt = kw_pos_r + 4'd1;
            if (kw_pos_r + 4'd1 == KW_EE_LEN) phase_nxt = PH_EE_SP;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_EE_SP: begin
          if (in_char_in == CH_SPACE)  phase_nxt = phase_r;
          else if (in_char_in == CH_R) phase_nxt = PH_R_SP;
          else if (in_char_in == CH_W) phase_nxt = PH_W_SP;
          else                         phase_nxt = PH_FAIL;
        end
        PH_R_SP, PH_W_SP, PH_W_SP2: begin
          if (in_char_in == CH_SPACE) begin
            phase_nxt = phase_r;
          end else if (in_char_in == CH_ZERO) begin
            phase_nxt = (phase_r == PH_R_SP) ? PH_R_X :
                        (phase_r == PH_W_SP) ? PH_W_X : PH_V_X;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_R_X, PH_W_X, PH_V_X: begin
          if (in_char_in == CH_X_UP || in_char_in == CH_X_LO) begin
            digit_seen_nxt = 1'b0;
            phase_nxt = (phase_r == PH_R_X) ? PH_R_DIG :
                        (phase_r == PH_W_X) ? PH_W_DIG : PH_V_DIG;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_R_DIG, PH_W_DIG: begin
          if (is_hex) begin
            addr_acc_nxt   = {addr_acc_r[11:0], hex[3:0]};
            digit_seen_nxt = 1'b1;
          end else if (!digit_seen_r) begin
            phase_nxt = PH_FAIL;
          end else if (phase_r == PH_R_DIG) begin
            phase_nxt = PH_DONE_R;
          end else begin
            // write address must end in a space
            phase_nxt = (in_char_in == CH_SPACE) ? PH_W_SP2 : PH_FAIL;
          end
        end
        PH_V_DIG: begin
          if (is_hex) begin
            val_acc_nxt    = {val_acc_r[3:0], hex[3:0]};
            digit_seen_nxt = 1'b1;
          end else begin
            phase_nxt = digit_seen_r ? PH_DONE_W : PH_FAIL;
          end
        end
        PH_KW_CAP: begin
          if (kw_pos_r < KW_CAP_LEN && in_char_in == kw_cap_char(kw_pos_r)) begin
            kw_pos_nxt = kw_pos_r + 4'd1;
            if (kw_pos_r + 4'd1 == KW_CAP_LEN) phase_nxt = PH_CAP_END;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_CAP_END: phase_nxt = PH_FAIL;
        // trailing text after a finished EEPROM command is ignored
        PH_DONE_R, PH_DONE_W: phase_nxt = phase_r;
        default: phase_nxt = PH_FAIL;
      endcase
    end
  end

  // Result formation and output register control
  always_comb begin
    res_valid_nxt = res_valid_r;
    res_dev_nxt   = res_dev_r;
    res_kind_nxt  = res_kind_r;
    res_addr_nxt  = res_addr_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load_res) begin
      out_valid_nxt = 1'b1;
      res_valid_nxt = 1'b0;
      res_dev_nxt   = 1'b0;
      res_kind_nxt  = 1'b0;
      res_addr_nxt  = '0;
      res_data_nxt  = '0;
      if (phase_r == PH_DONE_R || (phase_r == PH_R_DIG && digit_seen_r)) begin
        res_valid_nxt = 1'b1;
        res_addr_nxt  = addr_acc_r;
      end else if (phase_r == PH_DONE_W || (phase_r == PH_V_DIG && digit_seen_r)) begin
        res_valid_nxt = 1'b1;
        res_kind_nxt  = 1'b1;
        res_addr_nxt  = addr_acc_r;
        res_data_nxt  = val_acc_r;
      end else if (phase_r == PH_CAP_END) begin
        res_valid_nxt = 1'b1;
        res_dev_nxt   = 1'b1;
      end
    end
  end

  // Control and parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      kw_pos_r     <= '0;
      addr_acc_r   <= '0;
      val_acc_r    <= '0;
      digit_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      kw_pos_r     <= kw_pos_nxt;
      addr_acc_r   <= addr_acc_nxt;
      val_acc_r    <= val_acc_nxt;
      digit_seen_r <= digit_seen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    res_valid_r <= res_valid_nxt;
    res_dev_r   <= res_dev_nxt;
    res_kind_r  <= res_kind_nxt;
    res_addr_r  <= res_addr_nxt;
    res_data_r  <= res_data_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_cmd_valid      = res_valid_r;
  assign out_target_device  = res_dev_r;
  assign out_access_kind    = res_kind_r;
  assign out_target_address = res_addr_r;
  assign out_write_data     = res_data_r;

  // Checks
  a_term_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    load_res |=> (phase_r == PH_START && kw_pos_r == '0 && addr_acc_r == '0))
    else $error("parser not restarted after terminator");

  a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_res |=> out_valid_r)
    else $error("terminator transfer produced no result");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_valid_r) |->
      (!res_dev_r && !res_kind_r && res_addr_r == '0 && res_data_r == '0))
    else $error("invalid result carries nonzero fields");

  a_cap_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_dev_r) |->
      (res_valid_r && !res_kind_r && res_addr_r == '0 && res_data_r == '0))
    else $error("touch result carries EEPROM fields");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_FAIL)
    else $error("parse phase out of range");

endmodule
